/* rtl/core/utf8d_pkg.sv */
// utf8d_pkg: shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_step and utf8_stream_decoder; depends on nothing else.

package utf8d_pkg;

  // Field widths
  localparam int unsigned CP_W     = 31;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REMAIN_W = 3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CODE_POINT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_END        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_LEAD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_CONT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRUNCATED  = 3'd4;

  // Input actions
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // Most continuation bytes a lead can ask for
  localparam logic [REMAIN_W-1:0] MAX_REMAIN = 3'd5;

  // Decoder state carried from item to item
  typedef struct packed {
    logic [CP_W-1:0]     partial;
    logic [REMAIN_W-1:0] remaining;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic                valid;
    logic [CP_W-1:0]     code_point;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   bad_byte;
  } dec_result_t;

endpackage

/* rtl/core/utf8_stream_decoder.sv */
// utf8_stream_decoder: top level of the streaming six-byte UTF-8 decoder.
// Depends on utf8d_pkg and utf8d_step.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_action, in_data_byte    | in
//  result  | out_valid, out_stall, out_code_point, out_kind, | out
//          | out_bad_byte                                   |
//
// One item per cycle sustained while out_stall is low: an input register
// feeds the byte decoder, whose result is registered as the item advances.
// The decode state (partial value, bytes remaining) updates in the same
// cycle as the decode, so consecutive bytes follow without bubbles.
// Reset (rst_n low, synchronous) clears valid flags and the decode state.
// A stalled result holds; the input register keeps taking items until it
// holds one that cannot move into a full, stalled output register.

module utf8_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CP_W-1:0]    out_code_point,
  output logic [utf8d_pkg::KIND_W-1:0]  out_kind,
  output logic [utf8d_pkg::BYTE_W-1:0]  out_bad_byte
);
  import utf8d_pkg::*;

  logic              s1_valid_r;
  logic              s1_action_r;
  logic [BYTE_W-1:0] s1_byte_r;
  dec_state_t        state_r;
  dec_state_t        state_nxt;
  dec_result_t       step_res;
  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_bad_r;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  utf8d_step u_step (
    .state_cur (state_r),
    .action    (s1_action_r),
    .data_byte (s1_byte_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_data_byte;
    end
  end

  // Advance the decode state when an item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= step_res.valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (s1_adv && step_res.valid) begin
      out_cp_r   <= step_res.code_point;
      out_kind_r <= step_res.kind;
      out_bad_r  <= step_res.bad_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_kind       = out_kind_r;
  assign out_bad_byte   = out_bad_r;

  // Remaining count never exceeds the longest sequence
  a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.remaining <= MAX_REMAIN)
    else $error("bytes remaining out of range");

  // End of stream always returns the decoder to idle
  a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACT_EOS) |=> (state_r == '0))
    else $error("decoder not idle after end of stream");

  // Errors and markers carry no code point
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_CODE_POINT) |-> (out_cp_r == '0))
    else $error("code point set on non-code-point result");

  // Bad byte only on lead and continuation errors
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_BAD_LEAD && out_kind_r != KIND_BAD_CONT)
      |-> (out_bad_r == '0))
    else $error("bad byte set on non-error result");

endmodule

/* rtl/core/utf8d_step.sv */
// utf8d_step: combinational decode of one item against the current state.
// Depends on utf8d_pkg for state and result types.

module utf8d_step (
  input  utf8d_pkg::dec_state_t          state_cur,
  input  logic                           action,
  input  logic [utf8d_pkg::BYTE_W-1:0]   data_byte,
  output utf8d_pkg::dec_state_t          state_nxt,
  output utf8d_pkg::dec_result_t         result
);
  import utf8d_pkg::*;

  logic            is_cont;
  logic [CP_W-1:0] shifted;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign shifted = {state_cur.partial[CP_W-7:0], data_byte[5:0]};

  // Decode one byte or end-of-stream mark
  always_comb begin
    state_nxt         = state_cur;
    result.valid      = 1'b0;
    result.code_point = '0;
    result.kind       = KIND_CODE_POINT;
    result.bad_byte   = '0;
    if (action == ACT_EOS) begin
      // end of stream: flag truncation when inside a sequence
      state_nxt    = '0;
      result.valid = 1'b1;
      result.kind  = (state_cur.remaining != '0) ? KIND_TRUNCATED : KIND_END;
    end else if (state_cur.remaining == '0) begin
      // idle: ASCII, lead byte, or bad lead
      priority if (data_byte[7] == 1'b0) begin
        result.valid      = 1'b1;
        result.code_point = {{(CP_W-BYTE_W){1'b0}}, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        state_nxt.partial   = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        state_nxt.remaining = 3'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        state_nxt.partial   = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        state_nxt.remaining = 3'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        state_nxt.partial   = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        state_nxt.remaining = 3'd3;
      end else if (data_byte[7:2] == 6'b111110) begin
        state_nxt.partial   = {{(CP_W-2){1'b0}}, data_byte[1:0]};
        state_nxt.remaining = 3'd4;
      end else if (data_byte[7:1] == 7'b1111110) begin
        state_nxt.partial   = {{(CP_W-1){1'b0}}, data_byte[0]};
        state_nxt.remaining = MAX_REMAIN;
      end else begin
        result.valid    = 1'b1;
        result.kind     = KIND_BAD_LEAD;
        result.bad_byte = data_byte;
      end
    end else if (!is_cont) begin
      // drop the partial sequence, consume the byte
      state_nxt       = '0;
      result.valid    = 1'b1;
      result.kind     = KIND_BAD_CONT;
      result.bad_byte = data_byte;
    end else if (state_cur.remaining == 3'd1) begin
      // last continuation: emit the code point
      state_nxt         = '0;
      result.valid      = 1'b1;
      result.code_point = shifted;
    end else begin
      // gather six more bits
      state_nxt.partial   = shifted;
      state_nxt.remaining = state_cur.remaining - 3'd1;
    end
  end

endmodule
